@@ hw/rtl/char_lcd_four_bit_writer_unit_macros.svh @@
// assertion macros for the lcd writer unit
// bodies use the clock clk and the synchronous reset rst of the including module
`ifndef CHAR_LCD_FOUR_BIT_WRITER_UNIT_MACROS_SVH
`define CHAR_LCD_FOUR_BIT_WRITER_UNIT_MACROS_SVH

// same-cycle implication
`define CLCD4_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcd writer check failed");

// next-cycle implication
`define CLCD4_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcd writer check failed");

`endif

@@ hw/rtl/clcd4_pkg.sv @@
// shared types, codes and init tables for the lcd writer unit
// no dependencies
package clcd4_pkg;

  // request codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_WRITE_CMD = 2'd1;
  localparam logic [1:0] CMD_WRITE_DATA = 2'd2;
  localparam logic [1:0] CMD_INIT = 2'd3;

  // register indexes
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_POWER_UP_WAIT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_PULSE_TICKS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_POST_WRITE_WAIT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_CMD_WAIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_CMD_WAIT = 3'd4;

  // register reset values
  localparam logic [7:0] RST_POWER_UP_WAIT = 8'd100;
  localparam logic [3:0] RST_ENABLE_PULSE_TICKS = 4'd1;
  localparam logic [3:0] RST_POST_WRITE_WAIT = 4'd1;
  localparam logic [3:0] RST_LONG_CMD_WAIT = 4'd4;
  localparam logic [3:0] RST_SHORT_CMD_WAIT = 4'd1;

  // queue between front and back
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // ticks between the clear display command and the final command
  localparam logic [7:0] CLEAR_GAP_TICKS = 8'd4;

  typedef struct packed {
    logic [7:0] power_up_wait;
    logic [3:0] enable_pulse_ticks;
    logic [3:0] post_write_wait;
    logic [3:0] long_cmd_wait;
    logic [3:0] short_cmd_wait;
  } cfg_t;

  // decoded request
  typedef struct packed {
    logic       is_tick;
    logic       is_write;
    logic       is_data;
    logic       is_init;
    logic [7:0] value;
  } item_t;

  function automatic logic [3:0] boot_nibble(input logic [1:0] idx);
    logic [3:0] r;
    case (idx)
      2'd3: r = 4'h2;
      default: r = 4'h3;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] boot_gap(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = 8'd20;
      default: r = 8'd5;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] boot_cmd(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = 8'h28;
      2'd1: r = 8'h06;
      2'd2: r = 8'h01;
      default: r = 8'h0F;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/clcd4_if.sv @@
// request and result channel interfaces for the lcd writer unit
// no dependencies
interface clcd4_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] value;
  modport source (output valid, cmd, value, input ready);
  modport sink (input valid, cmd, value, output ready);
endinterface

interface clcd4_rsp_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic       enable;
  logic [3:0] bus_nibble;
  logic       busy_res;
  logic       rejected;
  modport source (output valid, reg_select, enable, bus_nibble, busy_res, rejected,
                  input ready);
  modport sink (input valid, reg_select, enable, bus_nibble, busy_res, rejected,
                output ready);
endinterface

@@ hw/rtl/clcd4_front.sv @@
// front end: takes requests and decodes them into queue entries
// depends on clcd4_pkg and clcd4_req_if
module clcd4_front import clcd4_pkg::*; (
  clcd4_req_if.sink req,
  output logic      push_valid,
  output item_t     push_item,
  input  logic      push_ready
);

  assign req.ready  = push_ready;
  assign push_valid = req.valid;

  always_comb begin
    push_item.is_tick  = (req.cmd == CMD_TICK);
    push_item.is_write = (req.cmd == CMD_WRITE_CMD) || (req.cmd == CMD_WRITE_DATA);
    push_item.is_data  = (req.cmd == CMD_WRITE_DATA);
    push_item.is_init  = (req.cmd == CMD_INIT);
    push_item.value    = req.value;
  end

endmodule

@@ hw/rtl/clcd4_queue.sv @@
// small fifo of decoded requests between front and back
// depends on clcd4_pkg
module clcd4_queue import clcd4_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  input  item_t push_item,
  output logic  push_ready,
  output logic  pop_valid,
  output item_t pop_item,
  input  logic  pop_ready
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  item_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/clcd4_back.sv @@
// back end: write/init sequencer, tick counter and result register
// depends on clcd4_pkg and clcd4_rsp_if
module clcd4_back import clcd4_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  item_valid,
  input  item_t item,
  output logic  item_ready,
  clcd4_rsp_if.source rsp
);

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_PWR_WAIT  = 3'd1;
  localparam logic [2:0] PH_INIT_NIB  = 3'd2;
  localparam logic [2:0] PH_INIT_GAP  = 3'd3;
  localparam logic [2:0] PH_W_HI      = 3'd4;
  localparam logic [2:0] PH_W_LO      = 3'd5;
  localparam logic [2:0] PH_W_POST    = 3'd6;
  localparam logic [2:0] PH_CLEAR_GAP = 3'd7;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] wcnt;
    logic [7:0] held;
    logic       is_data;
    logic [2:0] pos;
    logic       rs;
    logic       en;
    logic [3:0] nib;
  } seq_t;

  function automatic logic [7:0] pulse_len(input cfg_t c);
    return {4'd0, (c.enable_pulse_ticks == 4'd0) ? 4'd1 : c.enable_pulse_ticks};
  endfunction

  function automatic seq_t start_write(input seq_t s, input logic [7:0] b,
                                       input logic d, input cfg_t c);
    seq_t r;
    r         = s;
    r.held    = b;
    r.is_data = d;
    r.rs      = d;
    r.en      = 1'b1;
    r.nib     = b[7:4];
    r.phase   = PH_W_HI;
    r.wcnt    = pulse_len(c);
    return r;
  endfunction

  function automatic seq_t start_boot_nibble(input seq_t s, input cfg_t c);
    seq_t r;
    r       = s;
    r.rs    = 1'b0;
    r.en    = 1'b1;
    r.nib   = boot_nibble(s.pos[1:0]);
    r.phase = PH_INIT_NIB;
    r.wcnt  = pulse_len(c);
    return r;
  endfunction

  // one wait expiry: next action of the sequence
  function automatic seq_t expire(input seq_t s, input cfg_t c);
    seq_t       r;
    logic [3:0] extra;
    logic [2:0] pos_inc;
    r       = s;
    extra   = 4'd0;
    pos_inc = s.pos + 3'd1;
    case (s.phase)
      PH_PWR_WAIT: r = start_boot_nibble(s, c);
      PH_INIT_NIB: begin
        r.rs    = 1'b0;
        r.en    = 1'b0;
        r.phase = PH_INIT_GAP;
        r.wcnt  = boot_gap(s.pos[1:0]);
      end
      PH_INIT_GAP: begin
        r.pos = pos_inc;
        if (pos_inc < 3'd4) begin
          r = start_boot_nibble(r, c);
        end else begin
          r = start_write(r, boot_cmd(2'd0), 1'b0, c);
        end
      end
      PH_W_HI: begin
        r.rs    = s.is_data;
        r.en    = 1'b1;
        r.nib   = s.held[3:0];
        r.phase = PH_W_LO;
        r.wcnt  = pulse_len(c);
      end
      PH_W_LO: begin
        r.rs = s.is_data;
        r.en = 1'b0;
        if (!s.is_data) begin
          extra = (s.held < 8'd4) ? c.long_cmd_wait : c.short_cmd_wait;
        end
        r.phase = PH_W_POST;
        r.wcnt  = 8'(c.post_write_wait) + 8'(extra);
      end
      PH_W_POST: begin
        if (s.pos == 3'd6) begin
          r.phase = PH_CLEAR_GAP;
          r.wcnt  = CLEAR_GAP_TICKS;
        end else if (s.pos == 3'd4 || s.pos == 3'd5) begin
          r.pos = pos_inc;
          r     = start_write(r, boot_cmd(pos_inc[1:0]), 1'b0, c);
        end else begin
          r.phase = PH_IDLE;
          r.pos   = 3'd0;
          r.wcnt  = 8'd0;
        end
      end
      PH_CLEAR_GAP: begin
        r.pos = 3'd7;
        r     = start_write(r, boot_cmd(2'd3), 1'b0, c);
      end
      default: begin
        r.phase = PH_IDLE;
        r.pos   = 3'd0;
        r.wcnt  = 8'd0;
      end
    endcase
    return r;
  endfunction

  seq_t cur;
  seq_t s0;
  seq_t s1;
  seq_t s2;
  logic busy;
  logic reject;
  logic take;
  logic out_valid;

  assign busy       = (cur.phase != PH_IDLE);
  assign take       = item_valid && (!out_valid || rsp.ready);
  assign item_ready = !out_valid || rsp.ready;

  // apply the request, then pass at most two zero-length waits
  always_comb begin
    s0     = cur;
    reject = 1'b0;
    if (item.is_tick) begin
      if (busy && cur.wcnt != 8'd0) begin
        s0.wcnt = cur.wcnt - 8'd1;
      end
    end else if (busy) begin
      reject = 1'b1;
    end else if (item.is_init) begin
      s0.pos   = 3'd0;
      s0.rs    = 1'b0;
      s0.en    = 1'b0;
      s0.phase = PH_PWR_WAIT;
      s0.wcnt  = cfg.power_up_wait;
    end else if (item.is_write) begin
      s0.pos = 3'd0;
      s0     = start_write(s0, item.value, item.is_data, cfg);
    end
    s1 = (s0.phase != PH_IDLE && s0.wcnt == 8'd0) ? expire(s0, cfg) : s0;
    s2 = (s1.phase != PH_IDLE && s1.wcnt == 8'd0) ? expire(s1, cfg) : s1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        cur <= s2;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp.reg_select <= s2.rs;
      rsp.enable     <= s2.en;
      rsp.bus_nibble <= s2.nib;
      rsp.busy_res   <= (s2.phase != PH_IDLE);
      rsp.rejected   <= reject;
    end
  end

  assign rsp.valid = out_valid;

endmodule

@@ hw/rtl/char_lcd_four_bit_writer_unit.sv @@
// top level of the 4-bit character lcd writer
// depends on clcd4_pkg, clcd4_if, clcd4_front, clcd4_queue, clcd4_back and the macro header
// an accepted request goes into the queue; the result register loads when the back end takes it
// throughput: one request per cycle while the result side is ready, set by the sequencer update
// the queue keeps taking requests while a finished result waits on the output, until it is full
// reset (rst, synchronous): queue empty, sequencer idle, no result valid, registers to defaults
`include "char_lcd_four_bit_writer_unit_macros.svh"
module char_lcd_four_bit_writer_unit import clcd4_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  clcd4_req_if.sink              req,
  clcd4_rsp_if.source            rsp,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers, written by the user only while the unit is idle; not enforced
  cfg_t cfg;

  // front to queue
  logic  push_valid;
  logic  push_ready;
  item_t push_item;

  // queue to back
  logic  item_valid;
  logic  item_ready;
  item_t item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.power_up_wait      <= RST_POWER_UP_WAIT;
      cfg.enable_pulse_ticks <= RST_ENABLE_PULSE_TICKS;
      cfg.post_write_wait    <= RST_POST_WRITE_WAIT;
      cfg.long_cmd_wait      <= RST_LONG_CMD_WAIT;
      cfg.short_cmd_wait     <= RST_SHORT_CMD_WAIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POWER_UP_WAIT:      cfg.power_up_wait      <= cfg_data;
        REG_ENABLE_PULSE_TICKS: cfg.enable_pulse_ticks <= cfg_data[3:0];
        REG_POST_WRITE_WAIT:    cfg.post_write_wait    <= cfg_data[3:0];
        REG_LONG_CMD_WAIT:      cfg.long_cmd_wait      <= cfg_data[3:0];
        REG_SHORT_CMD_WAIT:     cfg.short_cmd_wait     <= cfg_data[3:0];
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // decode cmd into request flags
  clcd4_front u_front (
    .req        (req),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  // decouples request intake from the sequencer
  clcd4_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (item_valid),
    .pop_item   (item),
    .pop_ready  (item_ready)
  );

  // sequencer: ticks advance waits, writes and init run their nibble sequences
  clcd4_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .rsp        (rsp)
  );

  // an accepted request is waiting in the queue in the following cycle
  `CLCD4_ASSERT_NEXT(a_req_queued, req.valid && req.ready, item_valid)
  // a dropped request leaves the sequencer busy
  `CLCD4_ASSERT_NOW(a_reject_busy, rsp.valid && rsp.rejected, rsp.busy_res)
  // enable is only driven high inside a running sequence
  `CLCD4_ASSERT_NOW(a_enable_busy, rsp.valid && rsp.enable, rsp.busy_res)

endmodule

@@ test/char_lcd_line_checker.sv @@
// line-level checker for the 4-bit character lcd writer: predicts each result and compares it
// depends on clcd4_pkg and the request/result channel interfaces in clcd4_if
module char_lcd_line_checker import clcd4_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  clcd4_req_if                   req,
  clcd4_rsp_if                   rsp,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending,
  output logic                   model_busy
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    S_IDLE, S_POWER, S_BOOT_NIB, S_BOOT_GAP, S_HI, S_LO, S_POST, S_CLEAR
  } seq_state_t;

  typedef struct packed {
    logic       rs;
    logic       en;
    logic [3:0] nib;
    logic       busy;
    logic       rej;
  } lcd_lines_t;

  // init command bytes, lowest byte sent first
  localparam logic [31:0] BOOT_CMDS = {8'h0F, 8'h01, 8'h06, 8'h28};

  logic [7:0] pwr_ticks;
  logic [3:0] pulse_ticks, post_ticks, long_ticks, short_ticks;

  seq_state_t st;
  logic [7:0] cnt;
  logic [7:0] byte_q;
  logic       data_q;
  logic [3:0] boot_pos;
  logic       rs_l, en_l;
  logic [3:0] nib_l;

  lcd_lines_t expected_lines[$];

  assign model_busy = (st != S_IDLE);

  function automatic logic [7:0] pulse_len();
    return (pulse_ticks == 4'd0) ? 8'd1 : {4'd0, pulse_ticks};
  endfunction

  function automatic void start_write(input logic [7:0] b, input logic d);
    byte_q = b;
    data_q = d;
    rs_l = d;
    en_l = 1'b1;
    nib_l = b[7:4];
    st = S_HI;
    cnt = pulse_len();
  endfunction

  function automatic void start_boot_nibble();
    rs_l = 1'b0;
    en_l = 1'b1;
    nib_l = (boot_pos[1:0] == 2'd3) ? 4'h2 : 4'h3;
    st = S_BOOT_NIB;
    cnt = pulse_len();
  endfunction

  // one expiry of the current wait
  function automatic void advance();
    logic [7:0] extra;
    case (st)
      S_POWER: start_boot_nibble();
      S_BOOT_NIB: begin
        rs_l = 1'b0;
        en_l = 1'b0;
        st = S_BOOT_GAP;
        cnt = (boot_pos[1:0] == 2'd0) ? 8'd20 : 8'd5;
      end
      S_BOOT_GAP: begin
        boot_pos = boot_pos + 4'd1;
        if (boot_pos < 4'd4) start_boot_nibble();
        else start_write(BOOT_CMDS[7:0], 1'b0);
      end
      S_HI: begin
        rs_l = data_q;
        en_l = 1'b1;
        nib_l = byte_q[3:0];
        st = S_LO;
        cnt = pulse_len();
      end
      S_LO: begin
        en_l = 1'b0;
        if (data_q) extra = 8'd0;
        else if (byte_q < 8'd4) extra = {4'd0, long_ticks};
        else extra = {4'd0, short_ticks};
        st = S_POST;
        cnt = {4'd0, post_ticks} + extra;
      end
      S_POST: begin
        if (boot_pos == 4'd6) begin
          st = S_CLEAR;
          cnt = 8'd4;
        end else if (boot_pos >= 4'd4 && boot_pos < 4'd7) begin
          boot_pos = boot_pos + 4'd1;
          start_write(BOOT_CMDS[8*(boot_pos[1:0]) +: 8], 1'b0);
        end else begin
          st = S_IDLE;
          boot_pos = 4'd0;
          cnt = 8'd0;
        end
      end
      S_CLEAR: begin
        boot_pos = 4'd7;
        start_write(BOOT_CMDS[31:24], 1'b0);
      end
      default: begin
        st = S_IDLE;
        boot_pos = 4'd0;
        cnt = 8'd0;
      end
    endcase
  endfunction

  // zero-length waits pass within the same request
  function automatic void settle();
    while (st != S_IDLE && cnt == 8'd0) advance();
  endfunction

  function automatic lcd_lines_t predict_lines(input logic [1:0] c, input logic [7:0] v);
    lcd_lines_t r;
    logic rej;
    rej = 1'b0;
    if (c == CMD_TICK) begin
      if (st != S_IDLE && cnt > 8'd0) begin
        cnt = cnt - 8'd1;
        settle();
      end
    end else if (st != S_IDLE) begin
      rej = 1'b1;
    end else if (c == CMD_INIT) begin
      boot_pos = 4'd0;
      rs_l = 1'b0;
      en_l = 1'b0;
      st = S_POWER;
      cnt = pwr_ticks;
      settle();
    end else begin
      boot_pos = 4'd0;
      start_write(v, c == CMD_WRITE_DATA);
    end
    r.rs = rs_l;
    r.en = en_l;
    r.nib = nib_l;
    r.busy = (st != S_IDLE);
    r.rej = rej;
    return r;
  endfunction

  always @(posedge clk) begin
    lcd_lines_t want;
    if (rst) begin
      pwr_ticks = RST_POWER_UP_WAIT;
      pulse_ticks = RST_ENABLE_PULSE_TICKS;
      post_ticks = RST_POST_WRITE_WAIT;
      long_ticks = RST_LONG_CMD_WAIT;
      short_ticks = RST_SHORT_CMD_WAIT;
      st = S_IDLE;
      cnt = 8'd0;
      byte_q = 8'd0;
      data_q = 1'b0;
      boot_pos = 4'd0;
      rs_l = 1'b0;
      en_l = 1'b0;
      nib_l = 4'd0;
      expected_lines.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POWER_UP_WAIT: pwr_ticks = cfg_data[7:0];
          REG_ENABLE_PULSE_TICKS: pulse_ticks = cfg_data[3:0];
          REG_POST_WRITE_WAIT: post_ticks = cfg_data[3:0];
          REG_LONG_CMD_WAIT: long_ticks = cfg_data[3:0];
          REG_SHORT_CMD_WAIT: short_ticks = cfg_data[3:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) expected_lines.push_back(predict_lines(req.cmd, req.value));
      if (rsp.valid && rsp.ready) begin
        if (expected_lines.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count++;
        end else begin
          want = expected_lines.pop_front();
          if (rsp.reg_select !== want.rs) begin
            $error("reg_select: expected %0d, actual %0d", want.rs, rsp.reg_select);
            fail_count++;
          end
          if (rsp.enable !== want.en) begin
            $error("enable: expected %0d, actual %0d", want.en, rsp.enable);
            fail_count++;
          end
          if (rsp.bus_nibble !== want.nib) begin
            $error("bus_nibble: expected %0h, actual %0h", want.nib, rsp.bus_nibble);
            fail_count++;
          end
          if (rsp.busy_res !== want.busy) begin
            $error("busy_res: expected %0d, actual %0d", want.busy, rsp.busy_res);
            fail_count++;
          end
          if (rsp.rejected !== want.rej) begin
            $error("rejected: expected %0d, actual %0d", want.rej, rsp.rejected);
            fail_count++;
          end
        end
      end
    end
    pending = expected_lines.size();
  end

endmodule

@@ test/char_lcd_four_bit_writer_unit_tb.sv @@
// testbench top for the 4-bit character lcd writer: clock, reset, requests, settings, verdict
// depends on clcd4_pkg, clcd4_if, the writer unit and char_lcd_line_checker
module char_lcd_four_bit_writer_unit_tb import clcd4_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // slowest run: ~3k requests (counted ones, idle ticks, drains) under heavy stalls,
  // taken many times over
  localparam int CYCLE_LIMIT = 600000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  logic model_busy;
  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count;

  clcd4_req_if req_ch();
  clcd4_rsp_if rsp_ch();

  char_lcd_four_bit_writer_unit DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  char_lcd_line_checker lines_chk (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .pending(pending),
    .model_busy(model_busy)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // result-side back pressure, redrawn every cycle
  always @(negedge clk) begin
    if (!rst) rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one request: optional sender gaps, then hold valid until accepted
  // valid is left high on return so back-to-back requests need no second assignment
  task automatic send(input logic [1:0] c, input logic [7:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= c;
    req_ch.value <= v;
    @(posedge clk);
    while (!(req_ch.valid && req_ch.ready)) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
  endtask

  // only called with the block idle and every result collected
  task automatic load_settings(input logic [7:0] pwr, input logic [3:0] pulse,
                               input logic [3:0] post, input logic [3:0] lng,
                               input logic [3:0] sht);
    write_reg(REG_POWER_UP_WAIT, pwr);
    write_reg(REG_ENABLE_PULSE_TICKS, {4'd0, pulse});
    write_reg(REG_POST_WRITE_WAIT, {4'd0, post});
    write_reg(REG_LONG_CMD_WAIT, {4'd0, lng});
    write_reg(REG_SHORT_CMD_WAIT, {4'd0, sht});
    cfg_we <= 1'b0;
  endtask

  // tick the sequencer back to idle, then hold off until every result is in
  task automatic drain_to_idle();
    while (model_busy) send(CMD_TICK, 8'($urandom));
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // bytes near the long/short command boundary show up often
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(2) == 0) return 8'($urandom_range(0, 5));
    return 8'($urandom_range(0, 255));
  endfunction

  // edges of the fields, rejected requests, idle tick, zero waits (run with all-zero settings)
  task automatic directed_requests();
    send(CMD_TICK, 8'h00);        // tick while idle
    send(CMD_WRITE_CMD, 8'hFF);
    send(CMD_WRITE_DATA, 8'h00);  // dropped, still busy
    send(CMD_TICK, 8'hFF);        // enable stays high, low nibble on the bus
    send(CMD_TICK, 8'h00);        // zero post wait: back to idle in this step
    send(CMD_WRITE_DATA, 8'hFF);
    send(CMD_TICK, 8'h00);
    send(CMD_TICK, 8'h00);
    send(CMD_WRITE_CMD, 8'h03);   // below 4, long wait
    send(CMD_INIT, 8'hFF);        // dropped
    send(CMD_TICK, 8'h00);
    send(CMD_TICK, 8'h00);
    send(CMD_WRITE_CMD, 8'h04);   // first short-wait command
    send(CMD_TICK, 8'h00);
    send(CMD_TICK, 8'h00);
    send(CMD_WRITE_DATA, 8'h5A);
    send(CMD_TICK, 8'hFF);
    send(CMD_TICK, 8'h00);
    send(CMD_WRITE_CMD, 8'h00);
    send(CMD_TICK, 8'h00);
    send(CMD_TICK, 8'h00);
    send(CMD_INIT, 8'h00);        // zero power-up wait, first nibble right away
    send(CMD_WRITE_CMD, 8'h01);   // dropped
    send(CMD_TICK, 8'h00);
  endtask

  // mostly complete sequences: a request, then ticks until done, with stray requests
  // thrown in while busy; ticks at idle do nothing and are not counted
  task automatic random_requests(input int count);
    int sent;
    int r;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(99);
      if (model_busy) begin
        if (r < 88) send(CMD_TICK, 8'($urandom));
        else send(2'($urandom_range(1, 3)), 8'($urandom));
        sent++;
      end else if (r < 30) begin
        send(CMD_TICK, 8'($urandom));
      end else begin
        if (r < 33) send(CMD_INIT, 8'($urandom));
        else if (r < 66) send(CMD_WRITE_CMD, pick_byte());
        else send(CMD_WRITE_DATA, pick_byte());
        sent++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_TICK;
    req_ch.value = 8'd0;
    rsp_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_POWER_UP_WAIT;
    cfg_data = 8'd0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int ph = 0; ph < 6; ph++) begin
      // pacing: slow receiver, then slow sender, then full rate
      if (ph < 2) begin
        send_idle_pct = 9;
        recv_idle_pct = 85;
      end else if (ph < 4) begin
        send_idle_pct = 85;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case (ph)
        0: load_settings(8'd0, 4'd0, 4'd0, 4'd0, 4'd0);     // all waits zero, pulse 0 acts as 1
        1: load_settings(8'd100, 4'd1, 4'd1, 4'd4, 4'd1);   // power-on values
        2: load_settings(8'd255, 4'd15, 4'd15, 4'd15, 4'd15);
        3: load_settings(8'($urandom_range(0, 40)), 4'($urandom_range(1, 4)),
                         4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                         4'($urandom_range(0, 15)));
        4: load_settings(8'd7, 4'd2, 4'd0, 4'd15, 4'd0);
        default: load_settings(8'($urandom_range(0, 30)), 4'($urandom_range(1, 3)),
                               4'($urandom_range(0, 3)), 4'($urandom_range(0, 6)),
                               4'($urandom_range(0, 3)));
      endcase

      if (ph == 0) begin
        directed_requests();
        drain_to_idle();
      end

      case (ph)
        0: random_requests(250);
        1: random_requests(300);
        2: random_requests(350);
        3: random_requests(300);
        4: random_requests(300);
        default: random_requests(350);
      endcase
      drain_to_idle();
    end

    // let any stray result surface before the verdict
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ char_lcd_four_bit_writer_unit.f @@
+incdir+hw/rtl
hw/rtl/clcd4_pkg.sv
hw/rtl/clcd4_if.sv
hw/rtl/clcd4_front.sv
hw/rtl/clcd4_queue.sv
hw/rtl/clcd4_back.sv
hw/rtl/char_lcd_four_bit_writer_unit.sv
test/char_lcd_line_checker.sv
test/char_lcd_four_bit_writer_unit_tb.sv
